// File: hdl/encoder_and_button_event_qualifier_defines.svh
// Assertion macros for the encoder and button event qualifier checker.
// Used by ebq_checker.sv; needs nothing else.
`ifndef ENCODER_AND_BUTTON_EVENT_QUALIFIER_DEFINES_SVH
`define ENCODER_AND_BUTTON_EVENT_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define EBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebq: implication check failed");

// Next-cycle implication, disabled while reset is low
`define EBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebq: next-cycle check failed");

`endif

// File: hdl/ebq_pkg.sv
// Shared constants for the encoder and button event qualifier.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package ebq_pkg;

    // Stream payload widths (padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE_MS   = 2'd0,
        REG_HOLD_MS       = 2'd1,
        REG_COUNTS_DETENT = 2'd2,
        REG_REVERSE_DIR   = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [9:0]  DEBOUNCE_RST   = 10'd25;
    localparam logic [15:0] HOLD_RST       = 16'd750;
    localparam logic [3:0]  DETENT_RST     = 4'd4;

    // Item kinds carried on tuser
    localparam logic KIND_POLL   = 1'b0;
    localparam logic KIND_RESYNC = 1'b1;

    // Output field positions in tdata
    localparam int unsigned OUT_ROT_MSB = 8;
    localparam int unsigned OUT_CLICK   = 9;
    localparam int unsigned OUT_LONG    = 10;

endpackage

`default_nettype wire

// File: hdl/encoder_and_button_event_qualifier.sv
// Encoder and button event qualifier: debounce, click/long-press and detent logic.
// Depends on ebq_pkg.
//
// Usage:
//   Input stream (s_axis): one request per poll. tuser is the kind, 0 poll and
//   1 resync. A resync reloads button state from the current levels and
//   clears the detent residual; send one after reset.
//   Output stream (m_axis): exactly one result per request.
//   Config channel: register index and data, always ready; write only while
//   the block is idle.
// Timing:
//   A poll is worked by a sequencer over eight steps of a shared unit: a
//   one-bit restoring divider for the detent count and a 32-bit timestamp
//   subtract-and-compare used for at most one button check per step. A poll's
//   result becomes valid as the done state hands over, and tready returns in
//   that same cycle, so no new request is taken before that hand-over. A
//   resync skips the steps and goes straight to the done state.
//   The result sits in an output register; when the receiver stalls, one
//   finished result waits there while the next request is worked, and the
//   sequencer holds its own result (tready low) until that register frees.
// Reset: synchronous, active low; registers return to their reset values,
//   button state and residual clear, the output register empties.
`timescale 1ns / 1ps
`default_nettype none

module encoder_and_button_event_qualifier
    import ebq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata from bit 0: now_ms[31:0], encoder_delta[7:0], encoder_button_level,
    // left_level, right_level, ok_level, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind
    input  wire logic                  i_s_axis_tuser,
    // Output stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata from bit 0: rotation[8:0], click, long hold, left_press,
    // right_press, ok_press, zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Sequencer steps that run a timestamp check, and the last step
    localparam logic [2:0] STEP_ENC_DEB = 3'd0;
    localparam logic [2:0] STEP_LONG    = 3'd1;
    localparam logic [2:0] STEP_NAV0    = 3'd2;
    localparam logic [2:0] STEP_NAV1    = 3'd3;
    localparam logic [2:0] STEP_NAV2    = 3'd4;
    localparam logic [2:0] STEP_LAST    = 3'd7;

    t_state        r_state;
    logic [2:0]    r_step;

    // Configuration
    logic [9:0]    r_debounce;
    logic [15:0]   r_long_ms;
    logic [3:0]    r_cpd;
    logic          r_reverse;

    // Button and residual state
    logic [3:0]    r_residual;
    logic          r_enc_raw;
    logic          r_enc_stable;
    logic [31:0]   r_enc_chg;
    logic [31:0]   r_enc_press;
    logic          r_ignore_rel;
    logic          r_long_rep;
    logic [2:0]    r_nav_raw;
    logic [2:0]    r_nav_stable;
    logic [31:0]   r_nav_chg [3];

    // Request being worked
    logic [31:0]   r_now;
    logic          r_enc_lvl;
    logic [2:0]    r_nav_lvl;
    logic [3:0]    r_div;
    logic [3:0]    r_rem;
    logic [7:0]    r_quo;
    logic          r_sign;
    logic          r_neg;
    logic          r_click;
    logic          r_lp;
    logic [2:0]    r_np;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Input field views
    logic [31:0]   w_now;
    logic [7:0]    w_delta;
    logic          w_enc_lvl;
    logic [2:0]    w_nav_lvl;
    logic          w_accept;

    assign w_now     = i_s_axis_tdata[31:0];
    assign w_delta   = i_s_axis_tdata[39:32];
    assign w_enc_lvl = i_s_axis_tdata[40];
    assign w_nav_lvl = i_s_axis_tdata[43:41];
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    // Accumulate counts, split into sign and magnitude, clamp the divisor to 1..8
    logic [8:0]    n_acc;
    logic [8:0]    n_acc_mag;
    logic [3:0]    n_div;

    always_comb begin
        n_acc     = {{5{r_residual[3]}}, r_residual} + {w_delta[7], w_delta};
        n_acc_mag = n_acc[8] ? (~n_acc + 9'd1) : n_acc;
        if (r_cpd == 4'd0) begin
            n_div = 4'd1;
        end else if (r_cpd > 4'd8) begin
            n_div = 4'd8;
        end else begin
            n_div = r_cpd;
        end
    end

    // One restoring division step per cycle
    logic [3:0]    n_trial;
    logic          n_fits;
    logic [3:0]    n_rem;

    always_comb begin
        n_trial = {r_rem[2:0], r_quo[7]};
        n_fits  = (n_trial >= r_div);
        n_rem   = n_fits ? (n_trial - r_div) : n_trial;
    end

    // Shared timestamp subtract and compare, at most one button check per step
    logic [31:0]   n_t_sel;
    logic [31:0]   n_thr;
    logic [31:0]   n_diff;
    logic          n_ge;

    always_comb begin
        case (r_step)
            STEP_ENC_DEB: begin
                n_t_sel = r_enc_chg;
                n_thr   = {22'd0, r_debounce};
            end
            STEP_LONG: begin
                n_t_sel = r_enc_press;
                n_thr   = {16'd0, r_long_ms};
            end
            STEP_NAV0: begin
                n_t_sel = r_nav_chg[0];
                n_thr   = {22'd0, r_debounce};
            end
            STEP_NAV1: begin
                n_t_sel = r_nav_chg[1];
                n_thr   = {22'd0, r_debounce};
            end
            STEP_NAV2: begin
                n_t_sel = r_nav_chg[2];
                n_thr   = {22'd0, r_debounce};
            end
            default: begin
                n_t_sel = r_now;
                n_thr   = 32'd0;
            end
        endcase
        n_diff = r_now - n_t_sel;
        n_ge   = (n_diff >= n_thr);
    end

    // Signed rotation and residual from the finished division
    logic [8:0]    n_rot;
    logic [3:0]    n_resid;

    always_comb begin
        n_rot   = r_neg ? (~{1'b0, r_quo} + 9'd1) : {1'b0, r_quo};
        n_resid = r_sign ? (~r_rem + 4'd1) : r_rem;
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= 3'd0;
            r_debounce   <= DEBOUNCE_RST;
            r_long_ms    <= HOLD_RST;
            r_cpd        <= DETENT_RST;
            r_reverse    <= 1'b0;
            r_residual   <= 4'd0;
            r_enc_raw    <= 1'b0;
            r_enc_stable <= 1'b0;
            r_enc_chg    <= 32'd0;
            r_enc_press  <= 32'd0;
            r_ignore_rel <= 1'b0;
            r_long_rep   <= 1'b0;
            r_nav_raw    <= 3'd0;
            r_nav_stable <= 3'd0;
            for (int i = 0; i < 3; i++) begin
                r_nav_chg[i] <= 32'd0;
            end
            r_out_valid  <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_DEBOUNCE_MS:   r_debounce <= i_cfg_data[9:0];
                    REG_HOLD_MS:       r_long_ms  <= i_cfg_data[15:0];
                    REG_COUNTS_DETENT: r_cpd      <= i_cfg_data[3:0];
                    REG_REVERSE_DIR:   r_reverse  <= i_cfg_data[0];
                    default:           r_reverse  <= r_reverse;
                endcase
            end

            // Load a finished result, or drop the output once taken
            if ((r_state == S_DONE) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_now     <= w_now;
                        r_enc_lvl <= w_enc_lvl;
                        r_nav_lvl <= w_nav_lvl;
                        r_div     <= n_div;
                        r_rem     <= 4'd0;
                        r_click   <= 1'b0;
                        r_lp      <= 1'b0;
                        r_np      <= 3'd0;
                        r_step    <= 3'd0;
                        if (i_s_axis_tuser == KIND_RESYNC) begin
                            // Reload state from the current levels
                            r_quo        <= 8'd0;
                            r_sign       <= 1'b0;
                            r_neg        <= 1'b0;
                            r_enc_raw    <= w_enc_lvl;
                            r_enc_stable <= w_enc_lvl;
                            r_ignore_rel <= w_enc_lvl;
                            r_long_rep   <= w_enc_lvl;
                            r_enc_chg    <= w_now;
                            r_enc_press  <= w_now;
                            r_nav_raw    <= w_nav_lvl;
                            r_nav_stable <= w_nav_lvl;
                            for (int i = 0; i < 3; i++) begin
                                r_nav_chg[i] <= w_now;
                            end
                            r_state <= S_DONE;
                        end else begin
                            // Start division and record raw level changes
                            r_quo  <= n_acc_mag[7:0];
                            r_sign <= n_acc[8];
                            r_neg  <= n_acc[8] ^ r_reverse;
                            if (w_enc_lvl != r_enc_raw) begin
                                r_enc_raw <= w_enc_lvl;
                                r_enc_chg <= w_now;
                            end
                            for (int i = 0; i < 3; i++) begin
                                if (w_nav_lvl[i] != r_nav_raw[i]) begin
                                    r_nav_raw[i] <= w_nav_lvl[i];
                                    r_nav_chg[i] <= w_now;
                                end
                            end
                            r_state <= S_RUN;
                        end
                    end
                end

                S_RUN: begin
                    // Advance the divider one quotient bit
                    r_rem <= n_rem;
                    r_quo <= {r_quo[6:0], n_fits};

                    // Encoder button debounce
                    if (r_step == STEP_ENC_DEB) begin
                        if ((r_enc_lvl != r_enc_stable) && n_ge) begin
                            r_enc_stable <= r_enc_lvl;
                            if (r_enc_lvl) begin
                                r_enc_press <= r_now;
                                r_long_rep  <= 1'b0;
                            end else if (r_ignore_rel) begin
                                r_ignore_rel <= 1'b0;
                                r_long_rep   <= 1'b0;
                            end else if (!r_long_rep) begin
                                r_click <= 1'b1;
                            end
                        end
                    end

                    // Long press, once per hold
                    if (r_step == STEP_LONG) begin
                        if (r_enc_stable && !r_long_rep && n_ge) begin
                            r_long_rep <= 1'b1;
                            r_lp       <= 1'b1;
                        end
                    end

                    // Navigation button debounce, one button per step
                    for (int i = 0; i < 3; i++) begin
                        if (r_step == 3'(STEP_NAV0 + 3'(i))) begin
                            if ((r_nav_lvl[i] != r_nav_stable[i]) && n_ge) begin
                                r_nav_stable[i] <= r_nav_lvl[i];
                                r_np[i]         <= r_nav_lvl[i];
                            end
                        end
                    end

                    if (r_step == STEP_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end

                S_DONE: begin
                    // Hand over once the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_data  <= {2'b00, r_np, r_lp, r_click, n_rot};
                        r_residual  <= n_resid;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// File: hdl/ebq_checker.sv
// Port-level checker for the encoder and button event qualifier, with its bind.
// Depends on ebq_pkg and encoder_and_button_event_qualifier_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_and_button_event_qualifier_defines.svh"

module ebq_checker
    import ebq_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [1:0]            i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Hold a stalled result
    `EBQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Go busy right after taking a request
    `EBQ_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // A new result only appears out of a busy cycle
    `EBQ_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready))

    // Click and long press never share a result
    `EBQ_ASSERT_IMP(a_click_long_excl, i_clk, i_rst_n, o_m_axis_tvalid, !(o_m_axis_tdata[OUT_CLICK] && o_m_axis_tdata[OUT_LONG]))

    // Rotation stays within one poll's reach
    `EBQ_ASSERT_IMP(a_rot_range, i_clk, i_rst_n, o_m_axis_tvalid, ($signed(o_m_axis_tdata[OUT_ROT_MSB:0]) <= 9'sd135) && ($signed(o_m_axis_tdata[OUT_ROT_MSB:0]) >= -9'sd135))

endmodule

bind encoder_and_button_event_qualifier ebq_checker u_ebq_checker (.*);

`default_nettype wire
